@@ rtl/broadcast_fifo_multi_reader_top_defines.svh @@
// Assertion macros shared by the broadcast FIFO checker.
`ifndef BROADCAST_FIFO_MULTI_READER_TOP_DEFINES_SVH
`define BROADCAST_FIFO_MULTI_READER_TOP_DEFINES_SVH

// Same-edge implication, clocked on clk_i, quiet while in reset.
`define BFMR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-edge implication, clocked on clk_i, quiet while in reset.
`define BFMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bfmr_pkg.sv @@
// Types and constants of the broadcast FIFO.
package bfmr_pkg;

  localparam int unsigned CFG_W  = 4;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic    done;
    status_e status;
    logic    pop_ok;
  } ctrl_res_t;

endpackage

@@ rtl/broadcast_fifo_multi_reader_top.sv @@
// Top level of the broadcast FIFO with several readers.
//
// Broadcast ring FIFO of DEPTH slots. Each pushed word must be popped once by
// every active consumer (1..MAX_CONSUMERS, set by the configuration register)
// before its slot is freed. A command beat is taken whenever start is high;
// busy never rises, so one command per cycle is accepted without gaps. Each
// command returns exactly one result beat on done_o: it passes the command
// register and then the bookkeeping logic, whose result register is loaded
// together with the registered read of the slot memory. The receiver cannot
// stall, so results must be taken on the cycle they appear. Refusals (full,
// empty, bad consumer index) leave the state untouched and return zero pop
// data. The consumer count may only be written while no command is in
// flight; it takes effect from the next push.
module broadcast_fifo_multi_reader_top import bfmr_pkg::*; #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned MAX_CONSUMERS = 8,
  parameter int unsigned DATA_WIDTH    = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command beat
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode_i,
  input  logic [CIDX_W-1:0] consumer_index_i,
  input  logic [WORD_W-1:0] push_data_i,
  // result beat
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [WORD_W-1:0] pop_data_o,
  // configuration write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  // stored word width: the data port carries at most WORD_W bits
  localparam int unsigned STORE_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam int unsigned PTR_W   = $clog2(DEPTH);

  // command register
  logic               vld_q;
  opcode_e            op_q;
  logic [CIDX_W-1:0]  cidx_q;
  logic [STORE_W-1:0] data_q;

  logic [CFG_W-1:0]   consumers_q;

  ctrl_res_t          res_d, res_q;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr, mem_raddr;
  logic [STORE_W-1:0] mem_rdata;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      consumers_q <= CFG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      consumers_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q   <= opcode_e'(opcode_i);
      cidx_q <= consumer_index_i;
      data_q <= push_data_i[STORE_W-1:0];
    end
  end

  bfmr_ctrl #(
    .DEPTH        (DEPTH),
    .MAX_CONSUMERS(MAX_CONSUMERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (vld_q),
    .op_i       (op_q),
    .cidx_i     (cidx_q),
    .consumers_i(consumers_q),
    .res_o      (res_d),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_raddr_o(mem_raddr)
  );

  // read data lands in the same cycle as the result register
  bfmr_mem #(
    .DEPTH(DEPTH),
    .WIDTH(STORE_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(data_q),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign done_o     = res_q.done;
  assign status_o   = res_q.status;
  assign pop_data_o = res_q.pop_ok ? WORD_W'(mem_rdata) : '0;

endmodule

@@ rtl/bfmr_mem.sv @@
// Slot word memory: one write port, one registered read port.
module bfmr_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bfmr_ctrl.sv @@
// Pointer, pending-reader count and credit bookkeeping.
module bfmr_ctrl import bfmr_pkg::*; #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned MAX_CONSUMERS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     vld_i,
  input  opcode_e                  op_i,
  input  logic [CIDX_W-1:0]        cidx_i,
  input  logic [CFG_W-1:0]         consumers_i,
  output ctrl_res_t                res_o,
  output logic                     mem_we_o,
  output logic [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic [$clog2(DEPTH)-1:0] mem_raddr_o
);

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(MAX_CONSUMERS + 1);
  localparam int unsigned CRED_W = $clog2(DEPTH + 1);
  localparam int unsigned RIDX_W = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;

  logic [CNT_W-1:0]  cnt_q  [DEPTH];
  logic [CNT_W-1:0]  cnt_d  [DEPTH];
  logic [PTR_W-1:0]  rptr_q [MAX_CONSUMERS];
  logic [PTR_W-1:0]  rptr_d [MAX_CONSUMERS];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [CRED_W-1:0] cred_q, cred_d;

  logic [CNT_W-1:0]  eff;
  logic [RIDX_W-1:0] ridx;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W-1:0]  addr;
  logic [CNT_W-1:0]  cnt_rd;
  logic              bad_idx;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Out-of-range consumer counts are clamped to 1..MAX_CONSUMERS
  always_comb begin
    if (consumers_i == '0) begin
      eff = CNT_W'(1);
    end else if (32'(consumers_i) > 32'(MAX_CONSUMERS)) begin
      eff = CNT_W'(MAX_CONSUMERS);
    end else begin
      eff = CNT_W'(consumers_i);
    end
  end

  assign ridx    = RIDX_W'(cidx_i);
  assign bad_idx = 32'(cidx_i) >= 32'(eff);
  assign rptr    = bad_idx ? '0 : rptr_q[ridx];
  assign addr    = (op_i == OP_POP) ? rptr : wptr_q;
  assign cnt_rd  = cnt_q[addr];

  always_comb begin
    cnt_d        = cnt_q;
    rptr_d       = rptr_q;
    wptr_d       = wptr_q;
    cred_d       = cred_q;
    res_o.done   = vld_i;
    res_o.status = ST_OK;
    res_o.pop_ok = 1'b0;
    mem_we_o     = 1'b0;
    if (vld_i) begin
      unique case (op_i)
        OP_PUSH: begin
          if (cred_q == '0 || cnt_rd != '0) begin
            res_o.status = ST_FULL;
          end else begin
            cnt_d[wptr_q] = eff;
            wptr_d        = ptr_inc(wptr_q);
            cred_d        = cred_q - 1'b1;
            mem_we_o      = 1'b1;
          end
        end
        OP_POP: begin
          if (bad_idx) begin
            res_o.status = ST_BADIDX;
          end else if (cnt_rd == '0) begin
            res_o.status = ST_EMPTY;
          end else begin
            cnt_d[rptr]  = cnt_rd - 1'b1;
            rptr_d[ridx] = ptr_inc(rptr);
            res_o.pop_ok = 1'b1;
            // last reader hands the slot back
            if (cnt_rd == CNT_W'(1) && cred_q < CRED_W'(DEPTH)) begin
              cred_d = cred_q + 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < DEPTH; i++) cnt_d[i] = '0;
          for (int i = 0; i < MAX_CONSUMERS; i++) rptr_d[i] = '0;
          wptr_d = '0;
          cred_d = CRED_W'(DEPTH);
        end
        OP_NOP: ;
        default: ;
      endcase
    end
  end

  assign mem_waddr_o = wptr_q;
  assign mem_raddr_o = rptr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) cnt_q[i] <= '0;
      for (int i = 0; i < MAX_CONSUMERS; i++) rptr_q[i] <= '0;
      wptr_q <= '0;
      cred_q <= CRED_W'(DEPTH);
    end else begin
      cnt_q  <= cnt_d;
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      cred_q <= cred_d;
    end
  end

endmodule

@@ rtl/bfmr_checker.sv @@
// Port-level checks on the broadcast FIFO, bound to the top level.
`include "broadcast_fifo_multi_reader_top_defines.svh"

module bfmr_checker import bfmr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input logic [1:0]        opcode_i,
  input logic              done_i,
  input logic [1:0]        status_i,
  input logic [WORD_W-1:0] pop_data_i
);

  // every taken command answers with a result beat on done_i
  `BFMR_ASSERT_IMPL(a_cmd_answers, start_i && !busy_i, ##2 done_i, "command without result")

  // pop data only on a successful pop result
  `BFMR_ASSERT_IMPL(a_data_only_ok, pop_data_i != '0, done_i && status_i == ST_OK, "stray pop data")

  // empty and bad index refusals come from pops only
  `BFMR_ASSERT_IMPL(a_pop_refusal, done_i && (status_i == ST_EMPTY || status_i == ST_BADIDX), $past(opcode_i, 2) == OP_POP, "pop refusal on non-pop")

  // full refusals come from pushes only
  `BFMR_ASSERT_IMPL(a_full_push, done_i && status_i == ST_FULL, $past(opcode_i, 2) == OP_PUSH, "full refusal on non-push")

  // no pop data for anything but a pop
  `BFMR_ASSERT_IMPL(a_nonpop_zero, done_i && $past(opcode_i, 2) != OP_POP, pop_data_i == '0, "data on non-pop")

endmodule

bind broadcast_fifo_multi_reader_top bfmr_checker u_bfmr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start),
  .busy_i    (busy),
  .opcode_i  (opcode_i),
  .done_i    (done_o),
  .status_i  (status_o),
  .pop_data_i(pop_data_o)
);
